// ===== rtl/leg_inverse_kinematics_core_macros.svh =====
// Assertion helpers for the leg IK core
`ifndef LEG_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define LIK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked a fixed number of cycles after the antecedent
`define LIK_ASSERT_LATER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/legik_pkg.sv =====
`default_nettype none

package legik_pkg;

    // Defaults for top-level parameters
    localparam int LEG_COUNT_DEF       = 4;
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    // Internal angle format: 2^-16 degree
    localparam int IFRAC        = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_SHIFT = 24;
    localparam int H_FRAC       = 14;

    // Datapath widths
    localparam int AW    = 36;   // atan2 operand
    localparam int CW    = 62;   // CORDIC x/y
    localparam int ZW    = 26;   // angle accumulator
    localparam int RADW  = 64;   // square root radicand
    localparam int ROOTW = RADW / 2;

    // Pipeline depths of the front and back sections
    localparam int FRONT_LAT = 7;
    localparam int BACK_LAT  = 2;

    localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;

    typedef enum logic [2:0] {
        REG_FEMUR_LENGTH,
        REG_TIBIA_LENGTH,
        REG_LATERAL_REST_OFFSET,
        REG_VERTICAL_REST_OFFSET,
        REG_TIBIA_ANGLE_OFFSET,
        REG_RIGHT_SIDE_MASK,
        REG_JOINT_INVERT_MASK
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] foot_x;
        logic signed [15:0] foot_y;
        logic signed [15:0] foot_z;
        logic        [1:0]  leg_index;
    } target_t;

    typedef struct packed {
        logic [13:0] coxa_angle;
        logic [13:0] femur_angle;
        logic [13:0] tibia_angle;
        logic [1:0]  leg_echo;
        logic        reach_limited;
    } result_t;

    typedef struct packed {
        logic        [13:0] femur_length;
        logic        [13:0] tibia_length;
        logic signed [14:0] lateral_rest_offset;
        logic signed [14:0] vertical_rest_offset;
        logic signed [14:0] tibia_angle_offset;
        logic        [3:0]  right_side_mask;
        logic        [11:0] joint_invert_mask;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        femur_length:         14'd1008,
        tibia_length:         14'd1520,
        lateral_rest_offset:  15'sd544,
        vertical_rest_offset: -15'sd1280,
        tibia_angle_offset:   15'sd986,
        right_side_mask:      4'd10,
        joint_invert_mask:    12'd3591
    };

    // Sideband carried alongside the square roots
    typedef struct packed {
        logic signed [16:0]   x;
        logic signed [16:0]   y;
        logic signed [16:0]   z;
        logic signed [AW-1:0] knee_num;
        logic signed [AW-1:0] femur_num;
        logic                 knee_clamp;
        logic                 femur_clamp;
        logic                 reach_lim;
        logic [1:0]           leg;
        logic [2:0]           inv;
    } sq_meta_t;

    // Sideband carried alongside the CORDIC units
    typedef struct packed {
        logic       knee_clamp;
        logic       knee_neg;
        logic       femur_clamp;
        logic       femur_neg;
        logic       reach_lim;
        logic [1:0] leg;
        logic [2:0] inv;
    } cx_meta_t;

    // round(atan(2^-i) deg * 2^16)
    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic signed [ZW-1:0] e;
        unique case (i)
            0:  e = 26'sd2949120;
            1:  e = 26'sd1740967;
            2:  e = 26'sd919879;
            3:  e = 26'sd466945;
            4:  e = 26'sd234379;
            5:  e = 26'sd117304;
            6:  e = 26'sd58666;
            7:  e = 26'sd29335;
            8:  e = 26'sd14668;
            9:  e = 26'sd7334;
            10: e = 26'sd3667;
            11: e = 26'sd1833;
            12: e = 26'sd917;
            13: e = 26'sd458;
            14: e = 26'sd229;
            15: e = 26'sd115;
            16: e = 26'sd57;
            17: e = 26'sd29;
            18: e = 26'sd14;
            19: e = 26'sd7;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/leg_inverse_kinematics_core.sv =====
// Channel   Handshake               Payload
// command   start / busy            target   (foot_x, foot_y, foot_z, leg_index)
// result    done (strobe)           result   (coxa/femur/tibia angle, leg_echo, reach_limited)
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An accepted start reaches done through the setup math, the bit-per-stage square roots,
// 21 CORDIC stages and 2 output stages.
// A new target is accepted every cycle; busy stays low and cfg_ready stays high.
// Reset clears the valid bits and loads the register defaults.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none
`include "leg_inverse_kinematics_core_macros.svh"

module leg_inverse_kinematics_core
    import legik_pkg::*;
#(
    parameter int LEG_COUNT       = LEG_COUNT_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  target_t     target,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int SQ_LAT    = ROOTW;
    localparam int CX_LAT    = CORDIC_STEPS + 1;
    localparam int TOTAL_LAT = FRONT_LAT + SQ_LAT + CX_LAT + BACK_LAT;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_FEMUR_LENGTH:         cfg_reg.femur_length         <= cfg_data[13:0];
                REG_TIBIA_LENGTH:         cfg_reg.tibia_length         <= cfg_data[13:0];
                REG_LATERAL_REST_OFFSET:  cfg_reg.lateral_rest_offset  <= cfg_data;
                REG_VERTICAL_REST_OFFSET: cfg_reg.vertical_rest_offset <= cfg_data;
                REG_TIBIA_ANGLE_OFFSET:   cfg_reg.tibia_angle_offset   <= cfg_data;
                REG_RIGHT_SIDE_MASK:      cfg_reg.right_side_mask      <= cfg_data[3:0];
                REG_JOINT_INVERT_MASK:    cfg_reg.joint_invert_mask    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // setup math
    logic            f_valid;
    sq_meta_t        f_meta;
    logic [RADW-1:0] h_rad, k_rad, f_rad;

    legik_front #(
        .LEG_COUNT (LEG_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .target    (target),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .meta      (f_meta),
        .h_rad     (h_rad),
        .k_rad     (k_rad),
        .f_rad     (f_rad)
    );

    // square roots
    logic [ROOTW-1:0] h_root, k_root, f_root;

    legik_sqrt u_sqrt_h (.clk(clk), .radicand(h_rad), .root(h_root));
    legik_sqrt u_sqrt_k (.clk(clk), .radicand(k_rad), .root(k_root));
    legik_sqrt u_sqrt_f (.clk(clk), .radicand(f_rad), .root(f_root));

    // sideband beside the square roots
    logic [SQ_LAT-1:0] sqv_reg;
    sq_meta_t          sqm_reg [SQ_LAT];
    sq_meta_t          sqm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqv_reg <= '0;
        else
            sqv_reg <= {sqv_reg[SQ_LAT-2:0], f_valid};
    end

    always_ff @(posedge clk)
    begin
        sqm_reg[0] <= f_meta;
        for (int i = 1; i < SQ_LAT; i++)
            sqm_reg[i] <= sqm_reg[i-1];
    end

    assign sqm = sqm_reg[SQ_LAT-1];

    // CORDIC operands
    logic signed [AW-1:0] el_a, el_b, kn_a, fe_a;
    logic signed [ZW-1:0] yaw, elev, knee, femur;

    assign el_a = AW'(sqm.z) <<< H_FRAC;
    assign el_b = $signed(AW'(h_root));
    assign kn_a = $signed(AW'(k_root));
    assign fe_a = $signed(AW'(f_root));

    legik_cordic u_cx_yaw (.clk(clk), .a(AW'(sqm.x)), .b(AW'(sqm.y)), .angle(yaw));
    legik_cordic u_cx_elev (.clk(clk), .a(el_a), .b(el_b), .angle(elev));
    legik_cordic u_cx_knee (.clk(clk), .a(kn_a), .b(sqm.knee_num), .angle(knee));
    legik_cordic u_cx_femur (.clk(clk), .a(fe_a), .b(sqm.femur_num), .angle(femur));

    // sideband beside the CORDIC units
    logic [CX_LAT-1:0] cxv_reg;
    cx_meta_t          cxm_reg [CX_LAT];
    cx_meta_t          cx_in;

    always_comb
    begin
        cx_in.knee_clamp  = sqm.knee_clamp;
        cx_in.knee_neg    = sqm.knee_num[AW-1];
        cx_in.femur_clamp = sqm.femur_clamp;
        cx_in.femur_neg   = sqm.femur_num[AW-1];
        cx_in.reach_lim   = sqm.reach_lim;
        cx_in.leg         = sqm.leg;
        cx_in.inv         = sqm.inv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cxv_reg <= '0;
        else
            cxv_reg <= {cxv_reg[CX_LAT-2:0], sqv_reg[SQ_LAT-1]};
    end

    always_ff @(posedge clk)
    begin
        cxm_reg[0] <= cx_in;
        for (int i = 1; i < CX_LAT; i++)
            cxm_reg[i] <= cxm_reg[i-1];
    end

    // joint angles, clamping and rounding
    legik_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cxv_reg[CX_LAT-1]),
        .meta         (cxm_reg[CX_LAT-1]),
        .yaw          (yaw),
        .elev         (elev),
        .knee         (knee),
        .femur        (femur),
        .tibia_offset (cfg_reg.tibia_angle_offset),
        .out_valid    (done),
        .result       (result)
    );

    // checks
    `LIK_ASSERT_NOW(a_done_has_start, clk, rst_n, done, $past(start && !busy, TOTAL_LAT), "result without a matching transaction")
    `LIK_ASSERT_LATER(a_start_gives_done, clk, rst_n, start && !busy, TOTAL_LAT, done, "transaction lost in pipeline")
    `LIK_ASSERT_NOW(a_leg_echo, clk, rst_n, done, result.leg_echo == $past(target.leg_index, TOTAL_LAT), "leg index misaligned")

endmodule

`default_nettype wire

// ===== rtl/legik_front.sv =====
`default_nettype none

module legik_front
    import legik_pkg::*;
#(
    parameter int LEG_COUNT = LEG_COUNT_DEF
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  target_t         target,
    input  cfg_t            cfg,
    output logic            out_valid,
    output sq_meta_t        meta,
    output logic [RADW-1:0] h_rad,
    output logic [RADW-1:0] k_rad,
    output logic [RADW-1:0] f_rad
);

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic [1:0]         leg;
        logic [2:0]         inv;
    } carry_t;

    logic [FRONT_LAT-1:0] vld_reg;
    carry_t               carry_reg [FRONT_LAT-1];

    // stage 1: side mirror and rest offsets
    logic               leg_known;
    logic               right;
    logic [3:0]         inv_base;
    logic signed [16:0] fy_ext;
    carry_t             carry_next;

    assign leg_known = (32'(target.leg_index) < LEG_COUNT);
    assign right     = leg_known && cfg.right_side_mask[target.leg_index];
    assign inv_base  = 4'(target.leg_index) * 4'd3;
    assign fy_ext    = 17'(target.foot_y);

    always_comb
    begin
        carry_next.x   = 17'(target.foot_x);
        carry_next.y   = (right ? fy_ext : -fy_ext) + 17'(cfg.lateral_rest_offset);
        carry_next.z   = 17'(target.foot_z) + 17'(cfg.vertical_rest_offset);
        carry_next.leg = target.leg_index;
        carry_next.inv = leg_known ? cfg.joint_invert_mask[inv_base +: 3] : 3'b000;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
    end

    // stage 2..7 payload
    logic signed [33:0] xsq, ysq, zsq;
    logic [31:0] xx2_reg, yy2_reg, zz2_reg;
    logic [27:0] ff2_reg, tt2_reg, ff3_reg, tt3_reg;
    logic [32:0] h2_3_reg, h2_4_reg, h2_5_reg, h2_6_reg;
    logic [33:0] l2_3_reg;
    logic [55:0] fftt3_reg;
    logic signed [AW-1:0] knum4_reg, fnum4_reg, knum5_reg, fnum5_reg, knum6_reg, fnum6_reg;
    logic [63:0] kden4_reg, kden5_reg, kden6_reg, fden5_reg, fden6_reg;
    logic [44:0] fplo4_reg, fphi4_reg;
    logic        l2z4_reg, l2z5_reg, l2z6_reg;
    logic [AW-1:0] kmag5_reg, fmag5_reg;
    logic [63:0] kmsq6_reg, fmsq6_reg;
    logic        kbig6_reg, fbig6_reg;
    logic        kclamp, fclamp;
    sq_meta_t    meta_reg;
    logic [RADW-1:0] hrad_reg, krad_reg, frad_reg;

    assign xsq = carry_reg[0].x * carry_reg[0].x;
    assign ysq = carry_reg[0].y * carry_reg[0].y;
    assign zsq = carry_reg[0].z * carry_reg[0].z;

    // cosine clamp tests
    assign kclamp = (kden6_reg == '0) || kbig6_reg || (kmsq6_reg > kden6_reg);
    assign fclamp = (fden6_reg == '0) || fbig6_reg || (fmsq6_reg > fden6_reg);

    always_ff @(posedge clk)
    begin
        carry_reg[0] <= carry_next;
        for (int i = 1; i < FRONT_LAT-1; i++)
            carry_reg[i] <= carry_reg[i-1];

        // squares
        xx2_reg <= xsq[31:0];
        yy2_reg <= ysq[31:0];
        zz2_reg <= zsq[31:0];
        ff2_reg <= 28'(cfg.femur_length) * 28'(cfg.femur_length);
        tt2_reg <= 28'(cfg.tibia_length) * 28'(cfg.tibia_length);

        // distances and knee denominator
        h2_3_reg  <= 33'(xx2_reg) + 33'(yy2_reg);
        l2_3_reg  <= 34'(xx2_reg) + 34'(yy2_reg) + 34'(zz2_reg);
        fftt3_reg <= 56'(ff2_reg) * 56'(tt2_reg);
        ff3_reg   <= ff2_reg;
        tt3_reg   <= tt2_reg;

        // numerators, femur denominator partial products
        knum4_reg <= AW'(ff3_reg) + AW'(tt3_reg) - AW'(l2_3_reg);
        fnum4_reg <= AW'(l2_3_reg) + AW'(ff3_reg) - AW'(tt3_reg);
        kden4_reg <= 64'({fftt3_reg, 2'b00});
        fplo4_reg <= 45'(l2_3_reg[16:0]) * 45'(ff3_reg);
        fphi4_reg <= 45'(l2_3_reg[33:17]) * 45'(ff3_reg);
        l2z4_reg  <= (l2_3_reg == '0);
        h2_4_reg  <= h2_3_reg;

        // magnitudes, femur denominator
        fden5_reg <= ((64'(fphi4_reg) << 17) + 64'(fplo4_reg)) << 2;
        kden5_reg <= kden4_reg;
        kmag5_reg <= knum4_reg[AW-1] ? AW'(-knum4_reg) : AW'(knum4_reg);
        fmag5_reg <= fnum4_reg[AW-1] ? AW'(-fnum4_reg) : AW'(fnum4_reg);
        knum5_reg <= knum4_reg;
        fnum5_reg <= fnum4_reg;
        l2z5_reg  <= l2z4_reg;
        h2_5_reg  <= h2_4_reg;

        // squared numerators
        kmsq6_reg <= kmag5_reg[31:0] * kmag5_reg[31:0];
        fmsq6_reg <= fmag5_reg[31:0] * fmag5_reg[31:0];
        kbig6_reg <= |kmag5_reg[AW-1:32];
        fbig6_reg <= |fmag5_reg[AW-1:32];
        kden6_reg <= kden5_reg;
        fden6_reg <= fden5_reg;
        knum6_reg <= knum5_reg;
        fnum6_reg <= fnum5_reg;
        l2z6_reg  <= l2z5_reg;
        h2_6_reg  <= h2_5_reg;

        // radicands and sideband
        krad_reg <= kden6_reg - kmsq6_reg;
        frad_reg <= fden6_reg - fmsq6_reg;
        hrad_reg <= 64'(h2_6_reg) << (2 * H_FRAC);
        meta_reg.x           <= carry_reg[FRONT_LAT-2].x;
        meta_reg.y           <= carry_reg[FRONT_LAT-2].y;
        meta_reg.z           <= carry_reg[FRONT_LAT-2].z;
        meta_reg.leg         <= carry_reg[FRONT_LAT-2].leg;
        meta_reg.inv         <= carry_reg[FRONT_LAT-2].inv;
        meta_reg.knee_num    <= knum6_reg;
        meta_reg.femur_num   <= fnum6_reg;
        meta_reg.knee_clamp  <= kclamp;
        meta_reg.femur_clamp <= fclamp;
        meta_reg.reach_lim   <= l2z6_reg || kclamp || fclamp;
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign meta      = meta_reg;
    assign h_rad     = hrad_reg;
    assign k_rad     = krad_reg;
    assign f_rad     = frad_reg;

endmodule

`default_nettype wire

// ===== rtl/legik_sqrt.sv =====
`default_nettype none

// Floor square root, one result bit per register stage
module legik_sqrt
    import legik_pkg::*;
(
    input  logic             clk,
    input  logic [RADW-1:0]  radicand,
    output logic [ROOTW-1:0] root
);

    localparam int REMW = ROOTW + 2;

    typedef struct packed {
        logic [RADW-1:0]  rad;
        logic [REMW-1:0]  rem;
        logic [ROOTW-1:0] root;
    } sq_stage_t;

    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t       o;
        logic [REMW+1:0] rs;
        logic [REMW+1:0] tr;
        rs    = {s.rem, s.rad[RADW-1 -: 2]};
        tr    = {2'b00, s.root, 2'b01};
        o.rad = s.rad << 2;
        if (rs >= tr)
        begin
            o.rem  = REMW'(rs - tr);
            o.root = {s.root[ROOTW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = REMW'(rs);
            o.root = {s.root[ROOTW-2:0], 1'b0};
        end
        return o;
    endfunction

    sq_stage_t st_reg [ROOTW];
    sq_stage_t st_init;

    always_comb
    begin
        st_init.rad  = radicand;
        st_init.rem  = '0;
        st_init.root = '0;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= sqrt_step(st_init);
        for (int k = 1; k < ROOTW; k++)
            st_reg[k] <= sqrt_step(st_reg[k-1]);
    end

    assign root = st_reg[ROOTW-1].root;

endmodule

`default_nettype wire

// ===== rtl/legik_cordic.sv =====
`default_nettype none

// Vectoring CORDIC atan2(a, b): an input fold register, then one micro-rotation per register stage
module legik_cordic
    import legik_pkg::*;
(
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [AW-1:0] b,
    output logic signed [ZW-1:0] angle
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cx_stage_t;

    function automatic cx_stage_t cordic_step(input cx_stage_t s, input int unsigned i);
        cx_stage_t o;
        o.zero = s.zero;
        if (s.y > 0)
        begin
            o.x = s.x + (s.y >>> i);
            o.y = s.y - (s.x >>> i);
            o.z = s.z + atan_entry(i);
        end
        else
        begin
            o.x = s.x - (s.y >>> i);
            o.y = s.y + (s.x >>> i);
            o.z = s.z - atan_entry(i);
        end
        return o;
    endfunction

    cx_stage_t            st_reg [CORDIC_STEPS+1];
    cx_stage_t            st_next;
    logic signed [CW-1:0] ax, bx;

    // scale and fold the left half-plane by a quarter turn
    always_comb
    begin
        ax           = CW'(a) <<< CORDIC_SHIFT;
        bx           = CW'(b) <<< CORDIC_SHIFT;
        st_next.zero = (a == '0) && (b == '0);
        st_next.x    = bx;
        st_next.y    = ax;
        st_next.z    = '0;
        if (bx < 0)
        begin
            if (ax >= 0)
            begin
                st_next.x = ax;
                st_next.y = -bx;
                st_next.z = DEG90;
            end
            else
            begin
                st_next.x = -ax;
                st_next.y = bx;
                st_next.z = -DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= st_next;
        for (int i = 0; i < CORDIC_STEPS; i++)
            st_reg[i+1] <= cordic_step(st_reg[i], i);
    end

    assign angle = st_reg[CORDIC_STEPS].zero ? '0 : st_reg[CORDIC_STEPS].z;

endmodule

`default_nettype wire

// ===== rtl/legik_back.sv =====
`default_nettype none

module legik_back
    import legik_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  cx_meta_t             meta,
    input  logic signed [ZW-1:0] yaw,
    input  logic signed [ZW-1:0] elev,
    input  logic signed [ZW-1:0] knee,
    input  logic signed [ZW-1:0] femur,
    input  logic signed [14:0]   tibia_offset,
    output logic                 out_valid,
    output result_t              result
);

    localparam int VW = 32;
    localparam int SH = IFRAC - ANGLE_FRAC_BITS;
    localparam logic [24:0] HALF = 25'(1) << (SH - 1);
    localparam logic [24:0] FULL = 25'(180) << ANGLE_FRAC_BITS;

    // clamp to 0..180, round half up, mirror if inverted
    function automatic logic [13:0] finish_angle(input logic signed [VW-1:0] v,
                                                 input logic inv);
        logic [24:0] c;
        logic [24:0] r;
        if (v < 0)
            c = '0;
        else if (v > VW'(DEG180))
            c = 25'(DEG180);
        else
            c = v[24:0];
        r = (c + HALF) >> SH;
        if (r > FULL)
            r = FULL;
        if (inv)
            r = FULL - r;
        return r[13:0];
    endfunction

    logic signed [ZW-1:0] j3, bsel;
    logic signed [VW-1:0] coxa_next, femur_next, tibia_next;
    logic signed [VW-1:0] coxa_reg, femur_reg, tibia_reg;
    logic [2:0]           inv_reg;
    logic [1:0]           leg_reg;
    logic                 lim_reg;
    logic [1:0]           vld_reg;
    result_t              result_reg;

    // clamped cosines replace the CORDIC answers
    always_comb
    begin
        if (meta.knee_clamp)
            j3 = meta.knee_neg ? DEG180 : '0;
        else
            j3 = knee;
        if (meta.femur_clamp)
            bsel = meta.femur_neg ? DEG180 : '0;
        else
            bsel = femur;
        coxa_next  = VW'(DEG90) - VW'(yaw);
        femur_next = VW'(DEG90) - (VW'(bsel) + VW'(elev));
        tibia_next = VW'(j3) + (VW'(tibia_offset) <<< SH) - VW'(DEG90);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        coxa_reg  <= coxa_next;
        femur_reg <= femur_next;
        tibia_reg <= tibia_next;
        inv_reg   <= meta.inv;
        leg_reg   <= meta.leg;
        lim_reg   <= meta.reach_lim;

        result_reg.coxa_angle    <= finish_angle(coxa_reg, inv_reg[0]);
        result_reg.femur_angle   <= finish_angle(femur_reg, inv_reg[1]);
        result_reg.tibia_angle   <= finish_angle(tibia_reg, inv_reg[2]);
        result_reg.leg_echo      <= leg_reg;
        result_reg.reach_limited <= lim_reg;
    end

    assign out_valid = vld_reg[1];
    assign result    = result_reg;

endmodule

`default_nettype wire
